// ===== rtl/oqr_pkg.sv =====
// Package with the beat types, request codes and sizing constants of the ordered queue.
package oqr_pkg;

    localparam int QueueDepthDefault = 16;
    localparam int TagWidthDefault   = 32;
    localparam int ItemWidth         = 32;
    localparam int CountWidth        = 5;

    typedef enum logic [2:0] {
        REQ_ADD  = 3'd0,
        REQ_DEL  = 3'd1,
        REQ_HAS  = 3'd2,
        REQ_HEAD = 3'd3,
        REQ_NEXT = 3'd4,
        REQ_ITEM = 3'd5
    } t_req;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [ItemWidth-1:0] item_value;
    } t_in_beat;

    typedef struct packed {
        logic                  status;
        logic [ItemWidth-1:0]  item_out;
        logic                  present;
        logic [CountWidth-1:0] count;
    } t_out_beat;

endpackage

// ===== rtl/oqr_store.sv =====
// Entry memory of the ordered queue: one write port and one registered read port.
module oqr_store #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 32,
    parameter int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [TAG_WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [TAG_WIDTH-1:0] o_rd_data
);
    logic [TAG_WIDTH-1:0] r_mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== rtl/ordered_queue_with_removal.sv =====
// Top level of the ordered queue with delete by value and a cursor.
//
//  Channel | Direction | Signals                              | Beat
//  input   | in        | i_in_valid, o_in_stall, i_in_beat    | oqr_pkg::t_in_beat
//  output  | out       | o_out_valid, i_out_stall, o_out_beat | oqr_pkg::t_out_beat
//
// One request is handled at a time. Add, unknown requests and cursor requests that find no entry
// go straight to the result beat; head, next and item with an entry read the entry memory first.
// Has and delete walk the entry memory one entry after another, and a delete then moves each entry
// behind the match down by one place.
// Reset is synchronous and clears the count, cursor and control; entries are not cleared.
// A new request is taken only when the output register is empty or its beat leaves that cycle.
module ordered_queue_with_removal
    import oqr_pkg::t_in_beat, oqr_pkg::t_out_beat;
#(
    parameter int QUEUE_DEPTH = oqr_pkg::QueueDepthDefault,
    parameter int TAG_WIDTH   = oqr_pkg::TagWidthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);
    import oqr_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (TAG_WIDTH < ItemWidth) ? TAG_WIDTH : ItemWidth;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_SHIFT_RD, S_SHIFT_WR, S_CURRD, S_DONE
    } t_state;

    t_state               r_state;
    logic [2:0]           r_req;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_cur;
    logic                 r_cur_valid;
    logic [CW-1:0]        r_idx;
    logic                 r_rd_pending;
    logic                 r_out_valid;
    t_out_beat            r_out;

    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [TAG_WIDTH-1:0] w_wr_data;
    logic [AW-1:0]        w_rd_addr;
    logic [TAG_WIDTH-1:0] w_rd_data;
    logic                 w_take;
    logic                 w_out_free;
    logic [TAG_WIDTH-1:0] w_in_tag;
    logic [ItemWidth-1:0] w_rd_item;
    logic [CW-1:0]        w_idx_p1;

    oqr_store #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_WIDTH(TAG_WIDTH), .AW(AW)) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free;
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign w_in_tag    = TAG_WIDTH'(i_in_beat.item_value);
    assign w_rd_item   = ItemWidth'(w_rd_data[IW-1:0]);
    assign w_idx_p1    = r_idx + CW'(1);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_data = w_in_tag;
        w_rd_addr = r_idx[AW-1:0];
        if (r_state == S_IDLE && w_take && i_in_beat.req_type == REQ_ADD
                && w_in_tag != '0 && r_count < CW'(QUEUE_DEPTH)) begin
            w_wr_en = 1'b1;
        end
        if (r_state == S_SHIFT_RD) begin
            w_rd_addr = w_idx_p1[AW-1:0];
        end
        if (r_state == S_SHIFT_WR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_idx[AW-1:0];
            w_wr_data = w_rd_data;
        end
        if (r_state == S_CURRD) begin
            w_rd_addr = r_cur[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cur        <= '0;
            r_cur_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rd_pending <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_req         <= i_in_beat.req_type;
                        r_tag         <= w_in_tag;
                        r_idx         <= '0;
                        r_rd_pending  <= 1'b0;
                        r_out.status  <= 1'b0;
                        r_out.item_out <= '0;
                        r_out.present <= 1'b0;
                        r_out.count   <= CountWidth'(r_count);
                        r_state       <= S_DONE;
                        case (i_in_beat.req_type)
                            REQ_ADD: begin
                                if (w_in_tag == '0 || r_count >= CW'(QUEUE_DEPTH)) begin
                                    r_out.status <= 1'b1;
                                end else begin
                                    if (r_count == '0) begin
                                        r_cur       <= '0;
                                        r_cur_valid <= 1'b1;
                                    end
                                    r_count     <= r_count + CW'(1);
                                    r_out.count <= CountWidth'(r_count + CW'(1));
                                end
                            end
                            REQ_DEL, REQ_HAS: begin
                                if (w_in_tag == '0) begin
                                    r_out.status <= 1'b1;
                                end else if (r_count == '0) begin
                                    r_out.status <= (i_in_beat.req_type == REQ_DEL);
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            REQ_HEAD: begin
                                r_cur       <= '0;
                                r_cur_valid <= (r_count != '0);
                                if (r_count != '0) begin
                                    r_state <= S_CURRD;
                                end else begin
                                    r_out.status <= 1'b1;
                                end
                            end
                            REQ_NEXT: begin
                                if (r_cur_valid && (r_cur + CW'(1)) < r_count) begin
                                    r_cur   <= r_cur + CW'(1);
                                    r_state <= S_CURRD;
                                end else begin
                                    if (r_cur_valid) begin
                                        r_cur <= r_cur + CW'(1);
                                    end
                                    r_cur_valid  <= 1'b0;
                                    r_out.status <= 1'b1;
                                end
                            end
                            REQ_ITEM: begin
                                if (r_cur_valid && r_cur < r_count) begin
                                    r_state <= S_CURRD;
                                end else begin
                                    r_out.status <= 1'b1;
                                end
                            end
                            default: begin
                                r_out.status <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    // Address r_idx was issued last cycle when r_rd_pending is set.
                    if (!r_rd_pending) begin
                        r_rd_pending <= 1'b1;
                    end else if (w_rd_data == r_tag) begin
                        r_rd_pending <= 1'b0;
                        if (r_req == REQ_HAS) begin
                            r_out.present <= 1'b1;
                            r_state       <= S_DONE;
                        end else begin
                            if (r_cur_valid) begin
                                if (r_cur > r_idx) begin
                                    r_cur <= r_cur - CW'(1);
                                    if ((r_cur - CW'(1)) >= (r_count - CW'(1))) begin
                                        r_cur_valid <= 1'b0;
                                    end
                                end else if (r_cur >= (r_count - CW'(1))) begin
                                    r_cur_valid <= 1'b0;
                                end
                            end
                            r_out.count <= CountWidth'(r_count - CW'(1));
                            if (w_idx_p1 < r_count) begin
                                r_state <= S_SHIFT_RD;
                            end else begin
                                r_count <= r_count - CW'(1);
                                r_state <= S_DONE;
                            end
                        end
                    end else if (w_idx_p1 < r_count) begin
                        r_idx        <= w_idx_p1;
                        r_rd_pending <= 1'b0;
                    end else begin
                        r_out.status <= (r_req == REQ_DEL);
                        r_state      <= S_DONE;
                    end
                end
                S_SHIFT_RD: begin
                    r_state <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    r_idx <= w_idx_p1;
                    if ((w_idx_p1 + CW'(1)) < r_count) begin
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_CURRD: begin
                    if (r_rd_pending) begin
                        r_out.item_out <= w_rd_item;
                        r_rd_pending   <= 1'b0;
                        r_state        <= S_DONE;
                    end else begin
                        r_rd_pending <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/oqr_checker.sv =====
// Port-level checker for the ordered queue, bound to the top level.
module oqr_port_checks
    import oqr_pkg::t_in_beat, oqr_pkg::t_out_beat;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);
    import oqr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("Stalled output beat changed.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.count <= CountWidth'(QueueDepthDefault))
        else $error("Count beyond queue depth.");

    a_present_has: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.present |-> !o_out_beat.status)
        else $error("Present with error status.");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Second beat taken while a request is in progress.");

    a_item_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.item_out != '0 |-> !o_out_beat.status)
        else $error("Item returned with error status.");
endmodule

bind ordered_queue_with_removal oqr_port_checks u_oqr_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_beat  (i_in_beat),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_beat (o_out_beat)
);
